FILE: hdl/tfc_pkg.sv
// Shared types, register codes and channel helpers of the texel format converter.
`timescale 1ns / 1ps

package tfc_pkg;

	// Default palette geometry
	localparam int DEF_PALETTE_ENTRIES      = 256;
	localparam int DEF_PALETTE_CHANNEL_BITS = 6;

	// Configuration port geometry: four 32-bit registers at byte addresses 0, 4, 8, 12
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CHANNEL_COUNTS = 2'd0;
	localparam reg_idx_t REG_CHANNEL_SHIFTS = 2'd1;
	localparam reg_idx_t REG_SOURCE_FORMAT  = 2'd2;
	localparam reg_idx_t REG_ALPHA_SOURCE   = 2'd3;

	typedef logic [15:0] counts_t;
	typedef logic [19:0] shifts_t;
	typedef logic [2:0]  src_fmt_t;
	typedef logic [1:0]  alpha_src_t;

	localparam counts_t    COUNTS_RESET  = 16'd1381;
	localparam shifts_t    SHIFTS_RESET  = 20'd171;

	localparam src_fmt_t   FMT_PALETTE   = 3'd0;
	localparam src_fmt_t   FMT_RGB565    = 3'd1;
	localparam src_fmt_t   FMT_RGB888    = 3'd2;
	localparam src_fmt_t   FMT_RGBA8888  = 3'd3;
	localparam src_fmt_t   FMT_BGRA8888  = 3'd4;

	localparam alpha_src_t ALPHA_CONST   = 2'd0;
	localparam alpha_src_t ALPHA_OPACITY = 2'd1;
	localparam alpha_src_t ALPHA_MASK    = 2'd2;
	localparam alpha_src_t ALPHA_DIRECT  = 2'd3;

	// Request kinds carried on tuser
	localparam logic REQ_CONVERT       = 1'b0;
	localparam logic REQ_PALETTE_WRITE = 1'b1;

	localparam logic [7:0] CHAN_FULL = 8'd255;

	// Keep the top cnt bits of an 8-bit channel (cnt above eight counts as eight)
	// and move them to bit position sh of the packed word.
	function automatic logic [31:0] place_channel(input logic [7:0] v,
			input logic [3:0] cnt, input logic [4:0] sh);
		logic [3:0] c;
		logic [7:0] top;
		c   = (cnt > 4'd8) ? 4'd8 : cnt;
		top = v >> (4'd8 - c);
		return {24'd0, top} << sh;
	endfunction

endpackage

FILE: hdl/tfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tfc_ram #(
	parameter int DATA_W = 18,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/texel_format_converter_core.sv
// Top level of the texel format converter: palette store, decode and ARGB packing.
`timescale 1ns / 1ps
// A convert request goes with its palette read into stage 1, then into the output register.
// Throughput: one request per cycle unless the output stalls; the palette RAM takes one
// access per cycle. A palette write finishes at its accept edge and produces no result.
// arst_n clears the configuration registers to their defaults and empties both stages;
// palette contents stay undefined until written.

module texel_format_converter_core
	import tfc_pkg::*;
#(
	parameter int PALETTE_ENTRIES      = DEF_PALETTE_ENTRIES,
	parameter int PALETTE_CHANNEL_BITS = DEF_PALETTE_CHANNEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] texel_word, [39:32] opacity_byte, [47:40] palette_addr,
	// [55:48] palette_red, [63:56] palette_green, [71:64] palette_blue
	input  logic [71:0]           s_tdata,
	// [0] req_type
	input  logic                  s_tuser,

	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] packed_texel
	output logic [31:0]           m_tdata,

	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int PB      = PALETTE_CHANNEL_BITS;
	localparam int ENTRY_W = 3 * PB;
	localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int PAD     = 8 - PB;
	// Largest stored channel value, seen as an 8-bit number
	localparam logic [7:0] CH_MAX8 = 8'((1 << PB) - 1);
	localparam logic [8:0] ENTRIES9 = 9'(PALETTE_ENTRIES);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	counts_t    counts_q;
	shifts_t    shifts_q;
	src_fmt_t   src_fmt_q;
	alpha_src_t alpha_src_q;

	logic     cfg_we;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q    <= COUNTS_RESET;
			shifts_q    <= SHIFTS_RESET;
			src_fmt_q   <= FMT_PALETTE;
			alpha_src_q <= ALPHA_CONST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CHANNEL_COUNTS: counts_q    <= pwdata[15:0];
				REG_CHANNEL_SHIFTS: shifts_q    <= pwdata[19:0];
				REG_SOURCE_FORMAT:  src_fmt_q   <= pwdata[2:0];
				REG_ALPHA_SOURCE:   alpha_src_q <= pwdata[1:0];
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		unique case (cfg_idx)
			REG_CHANNEL_COUNTS: prdata = {16'd0, counts_q};
			REG_CHANNEL_SHIFTS: prdata = {12'd0, shifts_q};
			REG_SOURCE_FORMAT:  prdata = {29'd0, src_fmt_q};
			REG_ALPHA_SOURCE:   prdata = {30'd0, alpha_src_q};
		endcase
	end

	// ------------------------------------------------------------------
	// Request fields
	// ------------------------------------------------------------------
	logic [31:0] in_texel;
	logic [7:0]  in_opacity;
	logic [7:0]  in_addr;
	logic [7:0]  in_red;
	logic [7:0]  in_green;
	logic [7:0]  in_blue;

	assign in_texel   = s_tdata[31:0];
	assign in_opacity = s_tdata[39:32];
	assign in_addr    = s_tdata[47:40];
	assign in_red     = s_tdata[55:48];
	assign in_green   = s_tdata[63:56];
	assign in_blue    = s_tdata[71:64];

	// ------------------------------------------------------------------
	// Handshake: stage 1 holds a convert request while its palette read is
	// in flight, stage 2 is the output register. Stage 1 moves on whenever
	// the output register is empty or being drained this cycle.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic in_fire;
	logic conv_fire;
	logic wr_fire;

	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign in_fire   = s_tvalid && s_tready;
	assign conv_fire = in_fire && (s_tuser == REQ_CONVERT);
	assign wr_fire   = in_fire && (s_tuser == REQ_PALETTE_WRITE);

	// ------------------------------------------------------------------
	// Palette store: written at the accept edge of a palette write, read at
	// the accept edge of a convert. The read data holds until the next
	// convert is accepted, so a stalled stage 1 keeps its entry.
	// ------------------------------------------------------------------
	logic              wr_in_range;
	logic              rd_in_range;
	logic [PB-1:0]     sat_r;
	logic [PB-1:0]     sat_g;
	logic [PB-1:0]     sat_b;
	logic [ENTRY_W-1:0] pal_wdata;
	logic [ENTRY_W-1:0] pal_rdata;

	assign wr_in_range = {1'b0, in_addr} < ENTRIES9;
	assign rd_in_range = {1'b0, in_texel[7:0]} < ENTRIES9;

	// Saturate each channel to the stored width
	assign sat_r = (in_red   > CH_MAX8) ? CH_MAX8[PB-1:0] : in_red[PB-1:0];
	assign sat_g = (in_green > CH_MAX8) ? CH_MAX8[PB-1:0] : in_green[PB-1:0];
	assign sat_b = (in_blue  > CH_MAX8) ? CH_MAX8[PB-1:0] : in_blue[PB-1:0];
	assign pal_wdata = {sat_b, sat_g, sat_r};

	tfc_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (PALETTE_ENTRIES),
		.ADDR_W (PAL_AW)
	) u_palette (
		.clk   (clk),
		.we    (wr_fire && wr_in_range),
		.waddr (in_addr[PAL_AW-1:0]),
		.wdata (pal_wdata),
		.re    (conv_fire),
		.raddr (in_texel[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1 register
	// ------------------------------------------------------------------
	logic [31:0] texel_s1;
	logic [7:0]  opacity_s1;
	logic        idx_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			// take a new convert or drop to empty
			valid_s1 <= conv_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (conv_fire) begin
			texel_s1   <= in_texel;
			opacity_s1 <= in_opacity;
			idx_ok_s1  <= rd_in_range;
		end
	end

	// ------------------------------------------------------------------
	// Decode to 8-bit channels and pack
	// ------------------------------------------------------------------
	logic [7:0]  dec_r;
	logic [7:0]  dec_g;
	logic [7:0]  dec_b;
	logic [7:0]  dec_abyte;
	logic        dec_has_alpha;
	logic        dec_mask_on;
	logic [7:0]  dec_a;
	logic [7:0]  pal_r8;
	logic [7:0]  pal_g8;
	logic [7:0]  pal_b8;
	logic [31:0] packed_word;

	// Widen palette channels by moving them to the top of the byte;
	// an index past the store reads as black
	assign pal_r8 = idx_ok_s1 ? (8'(pal_rdata[PB-1:0])       << PAD) : 8'd0;
	assign pal_g8 = idx_ok_s1 ? (8'(pal_rdata[2*PB-1:PB])    << PAD) : 8'd0;
	assign pal_b8 = idx_ok_s1 ? (8'(pal_rdata[3*PB-1:2*PB])  << PAD) : 8'd0;

	always_comb begin
		dec_abyte     = 8'd0;
		dec_has_alpha = 1'b0;
		dec_mask_on   = 1'b1;
		unique case (src_fmt_q)
			FMT_RGB565: begin
				dec_r = {texel_s1[15:11], 3'd0};
				dec_g = {texel_s1[10:5], 2'd0};
				dec_b = {texel_s1[4:0], 3'd0};
			end
			FMT_RGB888: begin
				dec_r = texel_s1[7:0];
				dec_g = texel_s1[15:8];
				dec_b = texel_s1[23:16];
			end
			FMT_RGBA8888: begin
				dec_r         = texel_s1[7:0];
				dec_g         = texel_s1[15:8];
				dec_b         = texel_s1[23:16];
				dec_abyte     = texel_s1[31:24];
				dec_has_alpha = 1'b1;
				dec_mask_on   = texel_s1[31:24] != 8'd0;
			end
			FMT_BGRA8888: begin
				dec_b         = texel_s1[7:0];
				dec_g         = texel_s1[15:8];
				dec_r         = texel_s1[23:16];
				dec_abyte     = texel_s1[31:24];
				dec_has_alpha = 1'b1;
				dec_mask_on   = texel_s1[31:24] != 8'd0;
			end
			default: begin
				// palette index, also for the unused format codes
				dec_r       = pal_r8;
				dec_g       = pal_g8;
				dec_b       = pal_b8;
				dec_mask_on = texel_s1[7:0] != 8'd0;
			end
		endcase
	end

	always_comb begin
		unique case (alpha_src_q)
			ALPHA_CONST:   dec_a = CHAN_FULL;
			ALPHA_OPACITY: dec_a = opacity_s1;
			ALPHA_MASK:    dec_a = dec_mask_on ? CHAN_FULL : 8'd0;
			ALPHA_DIRECT:  dec_a = dec_has_alpha ? dec_abyte : CHAN_FULL;
		endcase
	end

	assign packed_word = place_channel(dec_r, counts_q[3:0],   shifts_q[4:0])
			   | place_channel(dec_g, counts_q[7:4],   shifts_q[9:5])
			   | place_channel(dec_b, counts_q[11:8],  shifts_q[14:10])
			   | place_channel(dec_a, counts_q[15:12], shifts_q[19:15]);

	// ------------------------------------------------------------------
	// Stage 2: output register
	// ------------------------------------------------------------------
	logic [31:0] packed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			packed_s2 <= packed_word;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = packed_s2;

endmodule

FILE: hdl/tfc_checker.sv
// Port-level checks of the texel format converter and their bind to the top level.
`timescale 1ns / 1ps

module tfc_checker
	import tfc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the output register empty, nothing may block a new request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request blocked with empty output");

	// A fresh result comes from an earlier convert request that passed through stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == REQ_CONVERT), 2))
		else $error("result without a matching convert request");

endmodule

bind texel_format_converter_core tfc_checker u_tfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
